// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Shared sector type and sector codes for the HSV to RGB pixel pipeline.
package hsv2rgb_pkg;

  typedef logic [2:0] sector_t;

  localparam sector_t SEC_RED_YEL = 3'd0;  // (v, t, p)
  localparam sector_t SEC_YEL_GRN = 3'd1;  // (q, v, p)
  localparam sector_t SEC_GRN_CYN = 3'd2;  // (p, v, t)
  localparam sector_t SEC_CYN_BLU = 3'd3;  // (p, q, v)
  localparam sector_t SEC_BLU_MAG = 3'd4;  // (t, p, v)
  localparam sector_t SEC_MAG_RED = 3'd5;  // (v, p, q)
  localparam sector_t SEC_WRAP    = 3'd6;  // hue of exactly one

endpackage

// ===== hw/rtl/hsv2rgb_prep.sv =====
// Stage one: clamp the inputs, scale hue by six, split it into sector and fraction.
module hsv2rgb_prep #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [FRAC_BITS:0]         in_hue,
  input  logic [FRAC_BITS:0]         in_sat,
  input  logic [FRAC_BITS:0]         in_val,
  output logic                       vld,
  output hsv2rgb_pkg::sector_t       sector,
  output logic [FRAC_BITS-1:0]       frac,
  output logic [FRAC_BITS:0]         sat,
  output logic [FRAC_BITS:0]         val
);
  import hsv2rgb_pkg::*;

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [W-1:0]   hue_c;
  logic [W-1:0]   sat_nxt;
  logic [W-1:0]   val_nxt;
  logic [W+1:0]   hue6;
  sector_t        sec_raw;
  sector_t        sector_nxt;

  logic           vld_r;
  sector_t        sector_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [W-1:0]   sat_r;
  logic [W-1:0]   val_r;

  assign hue_c   = (in_hue > ONE) ? ONE : in_hue;
  assign sat_nxt = (in_sat > ONE) ? ONE : in_sat;
  assign val_nxt = (in_val > ONE) ? ONE : in_val;

  // six times hue as four times plus two times
  assign hue6    = {hue_c, 2'b00} + {1'b0, hue_c, 1'b0};
  assign sec_raw = hue6[FRAC_BITS+2:FRAC_BITS];
  assign sector_nxt = (sec_raw == SEC_WRAP) ? SEC_RED_YEL : sec_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    sector_r <= sector_nxt;
    frac_r   <= hue6[FRAC_BITS-1:0];
    sat_r    <= sat_nxt;
    val_r    <= val_nxt;
  end

  assign vld    = vld_r;
  assign sector = sector_r;
  assign frac   = frac_r;
  assign sat    = sat_r;
  assign val    = val_r;

endmodule

// ===== hw/rtl/hsv2rgb_mul.sv =====
// Stages two and three: inner products f*s, (1-f)*s and p, then q and t.
module hsv2rgb_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  hsv2rgb_pkg::sector_t       in_sector,
  input  logic [FRAC_BITS-1:0]       in_frac,
  input  logic [FRAC_BITS:0]         in_sat,
  input  logic [FRAC_BITS:0]         in_val,
  output logic                       vld,
  output hsv2rgb_pkg::sector_t       sector,
  output logic [FRAC_BITS:0]         val,
  output logic [FRAC_BITS:0]         p_val,
  output logic [FRAC_BITS:0]         q_val,
  output logic [FRAC_BITS:0]         t_val
);
  import hsv2rgb_pkg::*;

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // stage two
  logic [W-1:0]   frac_w;
  logic [W-1:0]   one_m_frac;
  logic [W-1:0]   one_m_sat;
  logic [2*W-1:0] prod_fs;
  logic [2*W-1:0] prod_fts;
  logic [2*W-1:0] prod_p;

  logic           vld2_r;
  sector_t        sector2_r;
  logic [W-1:0]   val2_r;
  logic [W-1:0]   fs_r;
  logic [W-1:0]   fts_r;
  logic [W-1:0]   p2_r;

  // stage three
  logic [W-1:0]   one_m_fs;
  logic [W-1:0]   one_m_fts;
  logic [2*W-1:0] prod_q;
  logic [2*W-1:0] prod_t;

  logic           vld3_r;
  sector_t        sector3_r;
  logic [W-1:0]   val3_r;
  logic [W-1:0]   p3_r;
  logic [W-1:0]   q3_r;
  logic [W-1:0]   t3_r;

  assign frac_w     = {1'b0, in_frac};
  assign one_m_frac = ONE - frac_w;
  assign one_m_sat  = ONE - in_sat;

  assign prod_fs  = {{W{1'b0}}, frac_w}     * {{W{1'b0}}, in_sat};
  assign prod_fts = {{W{1'b0}}, one_m_frac} * {{W{1'b0}}, in_sat};
  assign prod_p   = {{W{1'b0}}, in_val}     * {{W{1'b0}}, one_m_sat};

  assign one_m_fs  = ONE - fs_r;
  assign one_m_fts = ONE - fts_r;

  assign prod_q = {{W{1'b0}}, val2_r} * {{W{1'b0}}, one_m_fs};
  assign prod_t = {{W{1'b0}}, val2_r} * {{W{1'b0}}, one_m_fts};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld2_r <= in_vld;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    sector2_r <= in_sector;
    val2_r    <= in_val;
    fs_r      <= prod_fs[2*FRAC_BITS:FRAC_BITS];
    fts_r     <= prod_fts[2*FRAC_BITS:FRAC_BITS];
    p2_r      <= prod_p[2*FRAC_BITS:FRAC_BITS];

    sector3_r <= sector2_r;
    val3_r    <= val2_r;
    p3_r      <= p2_r;
    q3_r      <= prod_q[2*FRAC_BITS:FRAC_BITS];
    t3_r      <= prod_t[2*FRAC_BITS:FRAC_BITS];
  end

  assign vld    = vld3_r;
  assign sector = sector3_r;
  assign val    = val3_r;
  assign p_val  = p3_r;
  assign q_val  = q3_r;
  assign t_val  = t3_r;

endmodule

// ===== hw/rtl/hsv2rgb_sel.sv =====
// Stage four: route v, p, q and t to red, green and blue by sector.
module hsv2rgb_sel #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  hsv2rgb_pkg::sector_t       in_sector,
  input  logic [FRAC_BITS:0]         in_val,
  input  logic [FRAC_BITS:0]         in_p,
  input  logic [FRAC_BITS:0]         in_q,
  input  logic [FRAC_BITS:0]         in_t,
  output logic                       vld,
  output logic [FRAC_BITS:0]         red,
  output logic [FRAC_BITS:0]         green,
  output logic [FRAC_BITS:0]         blue
);
  import hsv2rgb_pkg::*;

  localparam int W = FRAC_BITS + 1;

  logic [W-1:0] red_nxt;
  logic [W-1:0] green_nxt;
  logic [W-1:0] blue_nxt;

  logic         vld_r;
  logic [W-1:0] red_r;
  logic [W-1:0] green_r;
  logic [W-1:0] blue_r;

  always_comb begin
    unique case (in_sector)
      SEC_RED_YEL: begin
        red_nxt = in_val; green_nxt = in_t;   blue_nxt = in_p;
      end
      SEC_YEL_GRN: begin
        red_nxt = in_q;   green_nxt = in_val; blue_nxt = in_p;
      end
      SEC_GRN_CYN: begin
        red_nxt = in_p;   green_nxt = in_val; blue_nxt = in_t;
      end
      SEC_CYN_BLU: begin
        red_nxt = in_p;   green_nxt = in_q;   blue_nxt = in_val;
      end
      SEC_BLU_MAG: begin
        red_nxt = in_t;   green_nxt = in_p;   blue_nxt = in_val;
      end
      default: begin
        red_nxt = in_val; green_nxt = in_p;   blue_nxt = in_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign vld   = vld_r;
  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

// ===== hw/rtl/hsv_to_rgb_pixel_core.sv =====
// Top level of the HSV to RGB pixel converter: four-stage pipeline.
//
//   channel   ports                                  handshake
//   input     in_hue, in_saturation, in_brightness   start high, busy low
//   result    out_red, out_green, out_blue           out_valid strobe, one cycle
//
// One pixel per clock; each taken beat passes the prep, the two multiplier and the select registers in turn.
// Latency is set by the two chained multiplier stages (f*s, then v*(1-f*s)),
// each followed by a register, plus the input and output registers.
// busy is always low: the receiver cannot stall, so nothing is ever held.
// Synchronous reset clears the valid bits only; payload registers are not reset.
module hsv_to_rgb_pixel_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [FRAC_BITS:0]   in_hue,
  input  logic [FRAC_BITS:0]   in_saturation,
  input  logic [FRAC_BITS:0]   in_brightness,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   out_red,
  output logic [FRAC_BITS:0]   out_green,
  output logic [FRAC_BITS:0]   out_blue
);
  import hsv2rgb_pkg::*;

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic                 accept;
  logic                 s1_vld;
  sector_t              s1_sector;
  logic [FRAC_BITS-1:0] s1_frac;
  logic [W-1:0]         s1_sat;
  logic [W-1:0]         s1_val;

  logic                 s3_vld;
  sector_t              s3_sector;
  logic [W-1:0]         s3_val;
  logic [W-1:0]         s3_p;
  logic [W-1:0]         s3_q;
  logic [W-1:0]         s3_t;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  hsv2rgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (accept),
    .in_hue (in_hue),
    .in_sat (in_saturation),
    .in_val (in_brightness),
    .vld    (s1_vld),
    .sector (s1_sector),
    .frac   (s1_frac),
    .sat    (s1_sat),
    .val    (s1_val)
  );

  hsv2rgb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s1_vld),
    .in_sector (s1_sector),
    .in_frac   (s1_frac),
    .in_sat    (s1_sat),
    .in_val    (s1_val),
    .vld       (s3_vld),
    .sector    (s3_sector),
    .val       (s3_val),
    .p_val     (s3_p),
    .q_val     (s3_q),
    .t_val     (s3_t)
  );

  hsv2rgb_sel #(.FRAC_BITS(FRAC_BITS)) u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s3_vld),
    .in_sector (s3_sector),
    .in_val    (s3_val),
    .in_p      (s3_p),
    .in_q      (s3_q),
    .in_t      (s3_t),
    .vld       (out_valid),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted beat did not come out after four cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##4 !out_valid)
    else $error("result strobe without an accepted beat");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= ONE) && (out_green <= ONE) && (out_blue <= ONE))
    else $error("result channel above one");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_brightness == '0) |->
      ##4 (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("zero brightness did not give black");
`endif

endmodule

// ===== dv/hsv_to_rgb_pixel_core_test.sv =====
// Self-checking testbench for the HSV to RGB pixel core: directed and random pixels.
package hsv_rgb_check_pkg;
  import hsv2rgb_pkg::*;

  localparam int TB_FRAC  = 16;
  localparam int UNITY    = 1 << TB_FRAC;
  localparam int CHAN_MAX = (1 << (TB_FRAC + 1)) - 1;

  typedef logic [TB_FRAC:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  class rgb_scoreboard;
    rgb_t rgb_due[$];
    int   mismatch_count;
    int   pixels_taken;
    int   rgb_seen;
    int   clamped_inputs;
    int   sector_hits[7];

    task flag(string msg);
      if (mismatch_count < 40) $display("MISMATCH %s", msg);
      mismatch_count++;
    endtask

    function longint unsigned clip_unity(chan_t x);
      if (x > UNITY) begin
        clamped_inputs++;
        return UNITY;
      end
      return x;
    endfunction

    function longint unsigned fx_scale(longint unsigned a, longint unsigned b);
      return (a * b) >> TB_FRAC;
    endfunction

    function rgb_t hsv_pixel_to_rgb(chan_t hue_in, chan_t sat_in, chan_t val_in);
      longint unsigned h, s, v, h6, f, p, q, t;
      sector_t sec;
      rgb_t px;
      h   = clip_unity(hue_in);
      s   = clip_unity(sat_in);
      v   = clip_unity(val_in);
      h6  = h * 6;
      sec = sector_t'(h6 >> TB_FRAC);
      f   = h6 & longint'(UNITY - 1);
      p   = fx_scale(v, UNITY - s);
      q   = fx_scale(v, UNITY - fx_scale(f, s));
      t   = fx_scale(v, UNITY - fx_scale(UNITY - f, s));
      sector_hits[sec]++;
      case (sec)
        SEC_RED_YEL, SEC_WRAP: px = '{red: chan_t'(v), green: chan_t'(t), blue: chan_t'(p)};
        SEC_YEL_GRN: px = '{red: chan_t'(q), green: chan_t'(v), blue: chan_t'(p)};
        SEC_GRN_CYN: px = '{red: chan_t'(p), green: chan_t'(v), blue: chan_t'(t)};
        SEC_CYN_BLU: px = '{red: chan_t'(p), green: chan_t'(q), blue: chan_t'(v)};
        SEC_BLU_MAG: px = '{red: chan_t'(t), green: chan_t'(p), blue: chan_t'(v)};
        default:     px = '{red: chan_t'(v), green: chan_t'(p), blue: chan_t'(q)};
      endcase
      return px;
    endfunction

    function void take_pixel(chan_t hue_in, chan_t sat_in, chan_t val_in);
      rgb_due.push_back(hsv_pixel_to_rgb(hue_in, sat_in, val_in));
      pixels_taken++;
    endfunction

    task match_rgb(chan_t r, chan_t g, chan_t b);
      rgb_t want;
      rgb_seen++;
      if (rgb_due.size() == 0) begin
        flag($sformatf("result %0d/%0d/%0d with no pixel pending", r, g, b));
        return;
      end
      want = rgb_due.pop_front();
      if (r !== want.red)
        flag($sformatf("red: got %0d expected %0d", r, want.red));
      if (g !== want.green)
        flag($sformatf("green: got %0d expected %0d", g, want.green));
      if (b !== want.blue)
        flag($sformatf("blue: got %0d expected %0d", b, want.blue));
    endtask
  endclass

endpackage

module hsv_to_rgb_pixel_core_test;
  import hsv_rgb_check_pkg::*;

  localparam int QUIET_LIMIT  = 400;
  localparam int RANDOM_BEATS = 1500;

  logic  clk           = 1'b0;
  logic  rst_n         = 1'b0;
  logic  start         = 1'b0;
  chan_t in_hue        = '0;
  chan_t in_saturation = '0;
  chan_t in_brightness = '0;
  logic  busy;
  logic  out_valid;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;

  rgb_scoreboard sb = new();
  int quiet_cycles = 0;

  hsv_to_rgb_pixel_core #(
    .FRAC_BITS(TB_FRAC)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid    (out_valid),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.take_pixel(in_hue, in_saturation, in_brightness);
    if (rst_n && out_valid !== 1'b0) sb.match_rgb(out_red, out_green, out_blue);
    if (rst_n && ((start && !busy) || out_valid)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic chan_t pick_channel();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 70) return chan_t'($urandom_range(0, UNITY));
    if (mode < 85) return chan_t'($urandom_range(0, CHAN_MAX));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return chan_t'(1);
      2:       return chan_t'(UNITY - 1);
      default: return chan_t'(UNITY);
    endcase
  endfunction

  task automatic send_pixel(input chan_t h, input chan_t s, input chan_t v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_brightness <= v;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    @(negedge clk);
    while (sb.rgb_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int stretch;
    int calm;
    int sectors_covered;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel('0, '0, '0, 0);
    send_pixel(chan_t'(UNITY), chan_t'(UNITY), chan_t'(UNITY), 0);
    send_pixel(chan_t'(CHAN_MAX), chan_t'(CHAN_MAX), chan_t'(CHAN_MAX), 1);
    send_pixel(chan_t'(UNITY + 1), chan_t'(UNITY / 2), chan_t'(50000), 0);
    send_pixel(chan_t'(UNITY), chan_t'(UNITY / 3), chan_t'(UNITY - 1), 2);
    for (int k = 1; k < 6; k++) begin
      send_pixel(chan_t'(k * UNITY / 6), chan_t'(UNITY), chan_t'(UNITY - 1), 0);
      send_pixel(chan_t'((k * UNITY + 5) / 6), chan_t'(UNITY), chan_t'(UNITY - 1),
                 $urandom_range(0, 3));
    end
    for (int k = 0; k < 6; k++)
      send_pixel(chan_t'((2 * k + 1) * UNITY / 12), pick_channel(), pick_channel(), 0);
    send_pixel(chan_t'(1), chan_t'(UNITY), chan_t'(UNITY), 0);
    send_pixel(chan_t'(UNITY - 1), chan_t'(UNITY - 1), chan_t'(UNITY), 0);
    drain_pixels();

    stretch = 0;
    calm    = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (stretch == 0) begin
        stretch = $urandom_range(20, 80);
        calm    = ($urandom_range(0, 9) < 3);
      end
      stretch--;
      if (n % 500 == 250) drain_pixels();
      send_pixel(pick_channel(), pick_channel(), pick_channel(),
                 calm ? 0 : $urandom_range(0, 12));
    end

    drain_pixels();
    repeat (8) @(posedge clk);
    if (sb.rgb_due.size() != 0)
      sb.flag($sformatf("%0d pixels never answered", sb.rgb_due.size()));

    sectors_covered = 0;
    for (int k = 0; k < 6; k++) if (sb.sector_hits[k] > 0) sectors_covered++;
    $display("Converted %0d pixels, checked %0d results; %0d of 6 sectors, %0d hue wraps,",
             sb.pixels_taken, sb.rgb_seen, sectors_covered, sb.sector_hits[6]);
    $display("%0d channels clamped above one, %0d mismatches.",
             sb.clamped_inputs, sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
